[rtl/core/eph_pkg.sv]
// ----------------------------------------------------------------------------
// eph_pkg
// Shared types and constants of the event polarity histogram.
// ----------------------------------------------------------------------------
package eph_pkg;

  localparam int FRAME_WIDTH_DEF  = 640;
  localparam int FRAME_HEIGHT_DEF = 480;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int ADDR_MAX_BITS = 24;

  localparam logic [15:0] SAT_LIM_RST = 16'd255;

  localparam logic [1:0] REQ_COUNT = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic REG_SAT_LIM = 1'b0;

  typedef enum logic [1:0] {
    OP_COUNT,
    OP_READ,
    OP_READ_OUT,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [ADDR_MAX_BITS-1:0] addr;
    logic                     pol;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

[rtl/core/eph_if.sv]
// ----------------------------------------------------------------------------
// eph_if
// Handshake channels of the event polarity histogram.
// ----------------------------------------------------------------------------
interface eph_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [9:0] pixel_x;
  logic [8:0] pixel_y;
  logic       polarity;

  modport source (output valid, req_type, pixel_x, pixel_y, polarity, input ready);
  modport sink   (input valid, req_type, pixel_x, pixel_y, polarity, output ready);
endinterface

interface eph_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] blue_level;
  logic       painted;

  modport source (output valid, red_level, blue_level, painted, input ready);
  modport sink   (input valid, red_level, blue_level, painted, output ready);
endinterface

[rtl/core/eph_ram.sv]
// ----------------------------------------------------------------------------
// eph_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module eph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/eph_fifo.sv]
// ----------------------------------------------------------------------------
// eph_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module eph_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  eph_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output eph_pkg::cmd_t cmd_o
);

  eph_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/core/eph_front.sv]
// ----------------------------------------------------------------------------
// eph_front
// Accept request words, drop those without effect, form pixel addresses.
// ----------------------------------------------------------------------------
module eph_front #(
  parameter int FRAME_WIDTH  = eph_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = eph_pkg::FRAME_HEIGHT_DEF
) (
  eph_evt_if.sink             evt_i,
  input  eph_pkg::back_stat_t stat_i,
  input  logic                full_i,
  output logic                push_o,
  output eph_pkg::cmd_t       cmd_o
);

  logic        in_frame;
  logic        keep;
  logic [31:0] idx_full;

  assign evt_i.ready = !full_i && !stat_i.clearing;

  always_comb begin
    in_frame = (32'(evt_i.pixel_x) < 32'(FRAME_WIDTH)) &&
               (32'(evt_i.pixel_y) < 32'(FRAME_HEIGHT));
    idx_full = 32'(evt_i.pixel_y) * 32'(FRAME_WIDTH) + 32'(evt_i.pixel_x);
    cmd_o.addr = idx_full[eph_pkg::ADDR_MAX_BITS-1:0];
    cmd_o.pol  = evt_i.polarity;
    cmd_o.op   = eph_pkg::OP_COUNT;
    keep       = 1'b0;
    unique case (evt_i.req_type)
      eph_pkg::REQ_COUNT: begin
        cmd_o.op = eph_pkg::OP_COUNT;
        keep     = in_frame;
      end
      eph_pkg::REQ_READ: begin
        cmd_o.op = in_frame ? eph_pkg::OP_READ : eph_pkg::OP_READ_OUT;
        keep     = 1'b1;
      end
      eph_pkg::REQ_CLEAR: begin
        cmd_o.op = eph_pkg::OP_CLEAR;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_o = evt_i.valid && evt_i.ready && keep;

endmodule

[rtl/core/eph_div.sv]
// ----------------------------------------------------------------------------
// eph_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eph_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [23:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  step_q;
  logic [15:0] rem_q, rem_d;
  logic [23:0] dq_q, dq_d;
  logic [15:0] dvs_q;
  logic [16:0] r_next;
  logic        ge;

  always_comb begin
    r_next = {rem_q, dq_q[23]};
    ge     = r_next >= {1'b0, dvs_q};
    rem_d  = ge ? 16'(r_next - {1'b0, dvs_q}) : r_next[15:0];
    dq_d   = {dq_q[22:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 5'd0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd23) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 16'd0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

[rtl/core/eph_back.sv]
// ----------------------------------------------------------------------------
// eph_back
// Sequence counter updates, color reads and clearing sweeps on the store.
// ----------------------------------------------------------------------------
module eph_back #(
  parameter int FRAME_WIDTH  = eph_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = eph_pkg::FRAME_HEIGHT_DEF,
  parameter int COUNT_BITS   = eph_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         sat_lim_i,
  input  logic                q_valid_i,
  input  eph_pkg::cmd_t       q_cmd_i,
  output logic                q_pop_o,
  output eph_pkg::back_stat_t stat_o,
  eph_res_if.source           res_o
);

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);
  localparam logic [16:0]   CAP_FULL  = (17'd1 << COUNT_BITS) - 17'd1;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e        state_q;
  eph_pkg::cmd_t cmd_q;
  logic [AW-1:0] clr_ptr_q;
  logic [7:0]    red_q, blue_q;
  logic          paint_q;
  logic          pos_win_q;

  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [15:0] eff_max, limit, cnt, neg, pos, diff;
  logic        red_hit, blue_hit, cnt_ok;
  logic [23:0] dividend, quotient;
  logic [7:0]  level;
  logic        div_start, div_done;

  always_comb begin
    eff_max  = (sat_lim_i == 16'd0) ? 16'd1 : sat_lim_i;
    limit    = (eff_max < CAP_FULL[15:0]) ? eff_max : CAP_FULL[15:0];
    neg      = ram_rdata[15:0];
    pos      = ram_rdata[31:16];
    cnt      = cmd_q.pol ? pos : neg;
    cnt_ok   = cnt < limit;
    red_hit  = (pos != 16'd0) && (pos >= neg);
    blue_hit = (neg != 16'd0) && (neg > pos);
    diff     = red_hit ? 16'(pos - neg) : 16'(neg - pos);
    dividend = {diff, 8'd0} - {8'd0, diff};
    level    = (quotient > 24'd255) ? 8'd255 : quotient[7:0];
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = cmd_q.addr[AW-1:0];
    ram_wdata = ram_rdata;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_ptr_q;
        ram_wdata = 32'd0;
      end
      ST_IDLE: begin
        q_pop_o  = q_valid_i;
        ram_addr = q_cmd_i.addr[AW-1:0];
        ram_en   = q_valid_i &&
                   (q_cmd_i.op == eph_pkg::OP_COUNT || q_cmd_i.op == eph_pkg::OP_READ);
      end
      ST_RD: begin
        if (cmd_q.op == eph_pkg::OP_COUNT) begin
          ram_en = cnt_ok;
          ram_we = cnt_ok;
          if (cmd_q.pol) begin
            ram_wdata = {16'(pos + 16'd1), neg};
          end else begin
            ram_wdata = {pos, 16'(neg + 16'd1)};
          end
        end else begin
          div_start = red_hit || blue_hit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_ptr_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLR: begin
          clr_ptr_q <= clr_ptr_q + AW'(1);
          if (clr_ptr_q == LAST_ADDR) begin
            clr_ptr_q <= '0;
            state_q   <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            unique case (q_cmd_i.op)
              eph_pkg::OP_CLEAR:    state_q <= ST_CLR;
              eph_pkg::OP_READ_OUT: state_q <= ST_OUT;
              default:              state_q <= ST_RD;
            endcase
          end
        end
        ST_RD: begin
          if (cmd_q.op == eph_pkg::OP_COUNT) begin
            state_q <= ST_IDLE;
          end else if (red_hit || blue_hit) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) begin
      cmd_q   <= q_cmd_i;
      red_q   <= 8'd0;
      blue_q  <= 8'd0;
      paint_q <= 1'b0;
    end
    if (state_q == ST_RD) begin
      paint_q   <= red_hit || blue_hit;
      pos_win_q <= red_hit;
    end
    if (state_q == ST_DIV && div_done) begin
      if (pos_win_q) begin
        red_q <= level;
      end else begin
        blue_q <= level;
      end
    end
  end

  eph_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (eff_max),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  eph_ram #(
    .WIDTH (32),
    .DEPTH (PIXELS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign stat_o.clearing  = (state_q == ST_CLR);
  assign res_o.valid      = (state_q == ST_OUT);
  assign res_o.red_level  = red_q;
  assign res_o.blue_level = blue_q;
  assign res_o.painted    = paint_q;

endmodule

[rtl/core/event_polarity_histogram.sv]
// ----------------------------------------------------------------------------
// event_polarity_histogram
// Per-pixel positive/negative event counters with color readout.
// ----------------------------------------------------------------------------
// Request words enter a two-entry queue and are executed one at a time on a
// single-port counter RAM. An event is read and then written back; a color
// read inside the frame is read, passed through the bit-serial divider when
// the pixel is painted, then waits until its result word is taken.
// After reset and for every clear request the RAM is swept one word per
// cycle over all FRAME_WIDTH*FRAME_HEIGHT words (307200 by default), during
// which no request word is accepted. The saturation limit register sits at
// byte address 0 of the APB port and resets to 255.
module event_polarity_histogram #(
  parameter int FRAME_WIDTH  = eph_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = eph_pkg::FRAME_HEIGHT_DEF,
  parameter int COUNT_BITS   = eph_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  eph_evt_if.sink     evt_i,
  eph_res_if.source   res_o
);

  logic [15:0]         sat_lim_q;
  logic                q_full, q_push, q_pop, q_valid;
  eph_pkg::cmd_t       push_cmd, q_cmd;
  eph_pkg::back_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == eph_pkg::REG_SAT_LIM) ? {16'd0, sat_lim_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_lim_q <= eph_pkg::SAT_LIM_RST;
    end else if (psel && penable && pwrite && paddr[2] == eph_pkg::REG_SAT_LIM) begin
      sat_lim_q <= pwdata[15:0];
    end
  end

  eph_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .evt_i  (evt_i),
    .stat_i (stat),
    .full_i (q_full),
    .push_o (q_push),
    .cmd_o  (push_cmd)
  );

  eph_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  eph_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sat_lim_i (sat_lim_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .stat_o    (stat),
    .res_o     (res_o)
  );

endmodule

[test/eph_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eph_tb_if
// Word types shared by the stimulus and checking sides of the testbench.
// ----------------------------------------------------------------------------
package eph_tb_pkg;

  typedef struct packed {
    logic [1:0] req;
    logic [9:0] x;
    logic [8:0] y;
    logic       pol;
  } evt_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] blue;
    logic       painted;
  } color_word_t;

  localparam logic [1:0] REQ_NONE = 2'd3;

endpackage

[test/event_polarity_histogram_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_polarity_histogram_tb
// Drives event, read and clear words through the histogram, keeps a model of
// the per-pixel counters and checks every color word, under random stalls on
// both channels and several saturation limits.
// ----------------------------------------------------------------------------
module event_polarity_histogram_tb;
  import eph_pkg::*;
  import eph_tb_pkg::*;

  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 125;

  typedef struct {
    evt_word_t   w;
    bit          typed;
    color_word_t c;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  eph_evt_if evt ();
  eph_res_if res ();

  event_polarity_histogram u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .evt_i  (evt.sink),
    .res_o  (res.source)
  );

  int unsigned  counts[int unsigned];
  logic [15:0]  max_cfg;
  color_word_t  color_q[$];
  int           errors = 0;
  int           colors_seen = 0;
  int           ready_wait = 0;
  bit           ready_burst = 0;
  bit           held_off = 0;
  dir_row_t     dir_rows[$];
  evt_word_t    hot[8];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[event_polarity_histogram] ERROR");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic int unsigned scale_color(int unsigned diff);
    int unsigned div;
    int unsigned v;
    div = (max_cfg == 0) ? 1 : max_cfg;
    v = (255 * diff) / div;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic bit histogram_apply(evt_word_t w, output color_word_t c);
    bit          in_frame;
    int unsigned idx;
    int unsigned word;
    int unsigned neg;
    int unsigned pos;
    int unsigned lim;
    c = '0;
    in_frame = (w.x < FRAME_WIDTH_DEF) && (w.y < FRAME_HEIGHT_DEF);
    idx = w.y * FRAME_WIDTH_DEF + w.x;
    word = (in_frame && counts.exists(idx)) ? counts[idx] : 0;
    neg = word & 16'hFFFF;
    pos = word >> 16;
    lim = (max_cfg == 0) ? 1 : max_cfg;
    case (w.req)
      REQ_COUNT: begin
        if (in_frame) begin
          if (w.pol && pos < lim) pos++;
          if (!w.pol && neg < lim) neg++;
          counts[idx] = (pos << 16) | neg;
        end
        return 0;
      end
      REQ_CLEAR: begin
        counts.delete();
        return 0;
      end
      REQ_READ: begin
        if (pos > 0 && pos >= neg) begin
          c.red = scale_color(pos - neg);
          c.painted = 1'b1;
        end else if (neg > 0 && neg > pos) begin
          c.blue = scale_color(neg - pos);
          c.painted = 1'b1;
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  task automatic apb_write(input logic [15:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 3'(4 * int'(REG_SAT_LIM));
    pwdata = {16'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    max_cfg = value;
  endtask

  task automatic send_word(input evt_word_t w, input int gap, input bit typed,
                           input color_word_t typed_c);
    color_word_t c;
    repeat (gap) begin
      @(negedge clk_i);
      evt.valid = 1'b0;
    end
    @(negedge clk_i);
    evt.valid = 1'b1;
    evt.req_type = w.req;
    evt.pixel_x = w.x;
    evt.pixel_y = w.y;
    evt.polarity = w.pol;
    do @(posedge clk_i); while (!evt.ready);
    if (histogram_apply(w, c)) color_q.push_back(typed ? typed_c : c);
  endtask

  task automatic drain_idle();
    @(negedge clk_i);
    evt.valid = 1'b0;
    wait (color_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic evt_word_t random_word();
    evt_word_t w;
    int        r;
    r = $urandom_range(99);
    w = hot[$urandom_range(7)];
    w.pol = 1'($urandom_range(1));
    if (r < 55) w.req = REQ_COUNT;
    else if (r < 80) w.req = REQ_READ;
    else begin
      w.x = $urandom_range(1) ? 10'($urandom_range(1023)) : 10'($urandom_range(639));
      w.y = $urandom_range(1) ? 9'($urandom_range(511)) : 9'($urandom_range(479));
      w.req = (r < 90) ? REQ_COUNT : (r < 98) ? REQ_READ : REQ_NONE;
    end
    return w;
  endfunction

  function automatic dir_row_t row(logic [1:0] req, int x, int y, bit pol, bit typed = 0,
                                   int red = 0, int blue = 0, bit painted = 0);
    dir_row_t d;
    d.w = '{req: req, x: 10'(x), y: 9'(y), pol: pol};
    d.typed = typed;
    d.c = '{red: 8'(red), blue: 8'(blue), painted: painted};
    return d;
  endfunction

  always @(negedge clk_i) res.ready = (ready_wait == 0);

  always @(posedge clk_i) begin
    if (ready_wait > 0) ready_wait = ready_wait - 1;
    else if (res.valid && res.ready) begin
      if (color_q.size() == 0) report("color word with none expected");
      else begin
        color_word_t e;
        e = color_q.pop_front();
        if (res.red_level !== e.red)
          report($sformatf("red %0d exp %0d", res.red_level, e.red));
        if (res.blue_level !== e.blue)
          report($sformatf("blue %0d exp %0d", res.blue_level, e.blue));
        if (res.painted !== e.painted)
          report($sformatf("painted %0b exp %0b", res.painted, e.painted));
      end
      colors_seen++;
      if (colors_seen % 60 == 0) ready_burst = ~ready_burst;
      if (!held_off && colors_seen == 40) begin
        held_off = 1;
        ready_wait = 400;
      end else ready_wait = ready_burst ? 0 : $urandom_range(8);
    end
  end

  initial begin
    logic [15:0] settings[NUM_PHASES];
    int          gap;
    evt.valid = 1'b0;
    evt.req_type = REQ_COUNT;
    evt.pixel_x = '0;
    evt.pixel_y = '0;
    evt.polarity = 1'b0;
    max_cfg = SAT_LIM_RST;
    settings = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd300, 16'd2, 16'd40, 16'd255};

    dir_rows = '{
      row(REQ_READ, 0, 0, 0, 1, 0, 0, 0),
      row(REQ_READ, 639, 479, 1, 1, 0, 0, 0),
      row(REQ_COUNT, 1, 1, 1),
      row(REQ_READ, 1, 1, 0, 1, 1, 0, 1),
      row(REQ_COUNT, 1, 1, 0),
      row(REQ_READ, 1, 1, 1, 1, 0, 0, 1),
      row(REQ_COUNT, 639, 479, 0),
      row(REQ_COUNT, 639, 479, 0),
      row(REQ_READ, 639, 479, 0, 1, 0, 2, 1),
      row(REQ_COUNT, 1023, 511, 1),
      row(REQ_COUNT, 640, 0, 1),
      row(REQ_COUNT, 0, 480, 0),
      row(REQ_READ, 1023, 511, 1, 1, 0, 0, 0),
      row(REQ_READ, 640, 0, 0, 1, 0, 0, 0),
      row(REQ_READ, 0, 480, 0, 1, 0, 0, 0),
      row(REQ_NONE, 5, 5, 1),
      row(REQ_NONE, 1023, 511, 0),
      row(REQ_COUNT, 0, 0, 1),
      row(REQ_READ, 0, 0, 0),
      row(REQ_CLEAR, 0, 0, 0),
      row(REQ_READ, 1, 1, 0, 1, 0, 0, 0),
      row(REQ_READ, 639, 479, 0, 1, 0, 0, 0)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].w, $urandom_range(2), dir_rows[i].typed, dir_rows[i].c);
    drain_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      apb_write(settings[p]);
      foreach (hot[k]) begin
        hot[k].x = (k == 0) ? 10'd0 : (k == 1) ? 10'd639 : 10'($urandom_range(639));
        hot[k].y = (k == 0) ? 9'd0 : (k == 1) ? 9'd479 : 9'($urandom_range(479));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        gap = ((n / 40) % 2) ? 0 : $urandom_range(8);
        send_word(random_word(), gap, 0, '0);
      end
      drain_idle();
    end

    wait (color_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && color_q.size() == 0) $display("[event_polarity_histogram] OK");
    else $display("[event_polarity_histogram] ERROR");
    $finish;
  end

endmodule
